// ----- sv/smmv_pkg.sv -----
// Shared constants and types of the stream mixing block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package smmv_pkg;

    // Fixed field widths of the stream beats
    localparam int LANES        = 8;
    localparam int SMP_W        = 16;
    localparam int COEF_W       = 16;
    localparam int IDX_W        = 7;
    localparam int CNT_W        = 4;
    localparam int MATRIX_DEPTH = LANES * LANES;
    localparam int GAIN_BASE    = MATRIX_DEPTH;
    localparam int GAIN_END     = MATRIX_DEPTH + LANES;

    // Datapath widths: exact product, partial sum of three, full sum of nine
    localparam int PROD_W = SMP_W + COEF_W;
    localparam int PART_W = PROD_W + 2;
    localparam int ACC_W  = PART_W + 2;

    // Configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic [CNT_W-1:0] COUNT_RST = CNT_W'(4);

    // Register indexes
    localparam logic REG_STREAM_COUNT = 1'b0;

    // Input function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_DATA = 1'b1;

    // Defaults of the top-level parameters
    localparam int MAX_STREAMS_DEF    = 8;
    localparam int SAMPLE_WIDTH_DEF   = 16;
    localparam int COEF_FRAC_BITS_DEF = 12;

    // One coefficient write into the store
    typedef struct packed {
        logic                     we;
        logic [IDX_W-1:0]         index;
        logic signed [COEF_W-1:0] value;
    } t_coef_wr;

    // Load enables of the three lane pipeline stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_pipe_en;

endpackage

`default_nettype wire

// ----- sv/smmv_if.sv -----
// Stream channel interfaces of the stream mixing block (input and result beats).
// Depends on smmv_pkg for field widths.
`default_nettype none

interface smmv_in_if
    import smmv_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic                     func;
    logic [IDX_W-1:0]         coef_index;
    logic signed [COEF_W-1:0] coef_value;
    logic signed [SMP_W-1:0]  x_value;
    logic signed [SMP_W-1:0]  res_lane0;
    logic signed [SMP_W-1:0]  res_lane1;
    logic signed [SMP_W-1:0]  res_lane2;
    logic signed [SMP_W-1:0]  res_lane3;
    logic signed [SMP_W-1:0]  res_lane4;
    logic signed [SMP_W-1:0]  res_lane5;
    logic signed [SMP_W-1:0]  res_lane6;
    logic signed [SMP_W-1:0]  res_lane7;

    modport source (
        output valid, func, coef_index, coef_value, x_value,
        output res_lane0, res_lane1, res_lane2, res_lane3,
        output res_lane4, res_lane5, res_lane6, res_lane7,
        input  ready
    );
    modport sink (
        input  valid, func, coef_index, coef_value, x_value,
        input  res_lane0, res_lane1, res_lane2, res_lane3,
        input  res_lane4, res_lane5, res_lane6, res_lane7,
        output ready
    );
endinterface

interface smmv_out_if
    import smmv_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] out_lane0;
    logic signed [SMP_W-1:0] out_lane1;
    logic signed [SMP_W-1:0] out_lane2;
    logic signed [SMP_W-1:0] out_lane3;
    logic signed [SMP_W-1:0] out_lane4;
    logic signed [SMP_W-1:0] out_lane5;
    logic signed [SMP_W-1:0] out_lane6;
    logic signed [SMP_W-1:0] out_lane7;

    modport source (
        output valid, out_lane0, out_lane1, out_lane2, out_lane3,
        output out_lane4, out_lane5, out_lane6, out_lane7,
        input  ready
    );
    modport sink (
        input  valid, out_lane0, out_lane1, out_lane2, out_lane3,
        input  out_lane4, out_lane5, out_lane6, out_lane7,
        output ready
    );
endinterface

`default_nettype wire

// ----- sv/smmv_apb_regs.sv -----
// APB register file of the stream mixing block: holds the stream count.
// Depends on smmv_pkg.
`default_nettype none

module smmv_apb_regs
    import smmv_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_psel,
    input  wire logic                  i_penable,
    input  wire logic                  i_pwrite,
    input  wire logic [APB_ADDR_W-1:0] i_paddr,
    input  wire logic [APB_DATA_W-1:0] i_pwdata,
    output logic      [APB_DATA_W-1:0] o_prdata,
    output logic                       o_pready,
    output logic      [CNT_W-1:0]      o_count
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             wr_hit;

    // Register select: word address above the byte offset
    assign wr_hit = i_psel && i_penable && i_pwrite && (i_paddr[2] == REG_STREAM_COUNT);

    always_comb begin
        n_count = r_count;
        if (wr_hit) begin
            n_count = i_pwdata[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_RST;
        end else begin
            r_count <= n_count;
        end
    end

    // Read-back; addresses beyond the list read zero
    always_comb begin
        o_prdata = '0;
        if (i_paddr[2] == REG_STREAM_COUNT) begin
            o_prdata = APB_DATA_W'(r_count);
        end
    end

    assign o_pready = 1'b1;
    assign o_count  = r_count;

endmodule

`default_nettype wire

// ----- sv/smmv_coef_store.sv -----
// Coefficient store: mixing matrix (entry i*8+o) and post gains, zero at reset.
// Depends on smmv_pkg. Every entry is read at a fixed place by one lane.
`default_nettype none

module smmv_coef_store
    import smmv_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_coef_wr                 i_wr,
    output logic signed [COEF_W-1:0]      o_mix  [MATRIX_DEPTH],
    output logic signed [COEF_W-1:0]      o_gain [LANES]
);

    logic signed [COEF_W-1:0] r_mix  [MATRIX_DEPTH];
    logic signed [COEF_W-1:0] r_gain [LANES];
    logic                     mix_we;
    logic                     gain_we;

    // Index decode; indexes past the gains are dropped
    assign mix_we  = i_wr.we && (i_wr.index < IDX_W'(GAIN_BASE));
    assign gain_we = i_wr.we && (i_wr.index >= IDX_W'(GAIN_BASE))
                             && (i_wr.index < IDX_W'(GAIN_END));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MATRIX_DEPTH; k++) begin
                r_mix[k] <= '0;
            end
            for (int k = 0; k < LANES; k++) begin
                r_gain[k] <= '0;
            end
        end else begin
            if (mix_we) begin
                r_mix[i_wr.index[$clog2(MATRIX_DEPTH)-1:0]] <= i_wr.value;
            end
            if (gain_we) begin
                r_gain[i_wr.index[$clog2(LANES)-1:0]] <= i_wr.value;
            end
        end
    end

    assign o_mix  = r_mix;
    assign o_gain = r_gain;

endmodule

`default_nettype wire

// ----- sv/smmv_lane.sv -----
// One output lane: nine products, two-level sum, round and saturate.
// Depends on smmv_pkg; stage loads come from the top-level pipeline control.
`default_nettype none

module smmv_lane
    import smmv_pkg::*;
#(
    parameter int LANE           = 0,
    parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire t_pipe_en                 i_en,
    input  wire logic [CNT_W-1:0]         i_count,
    input  wire logic signed [SMP_W-1:0]  i_x,
    input  wire logic signed [SMP_W-1:0]  i_res  [LANES],
    input  wire logic signed [COEF_W-1:0] i_col  [LANES],
    input  wire logic signed [COEF_W-1:0] i_gain,
    output logic signed [SMP_W-1:0]       o_result
);

    localparam int TERMS = LANES + 1;
    localparam int GROUPS = 3;
    localparam logic signed [PART_W-1:0] HALF = PART_W'(64'sd1 <<< (COEF_FRAC_BITS - 1));
    localparam longint SAT_HI_L = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1;
    localparam longint SAT_LO_L = -SAT_HI_L - 64'sd1;
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(SAT_HI_L);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(SAT_LO_L);

    logic signed [PROD_W-1:0] r_prod [TERMS];
    logic signed [PROD_W-1:0] n_prod [TERMS];
    logic signed [PART_W-1:0] r_part [GROUPS];
    logic signed [PART_W-1:0] n_part [GROUPS];
    logic signed [SMP_W-1:0]  r_out;
    logic signed [SMP_W-1:0]  n_out;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  rnd;
    logic                     lane_on;

    assign lane_on = CNT_W'(LANE) < i_count;

    // Stage 1: products, idle streams and idle lanes forced to zero
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            n_prod[i] = '0;
            if (lane_on && (CNT_W'(i) < i_count)) begin
                n_prod[i] = i_col[i] * i_res[i];
            end
        end
        n_prod[LANES] = '0;
        if (lane_on) begin
            n_prod[LANES] = i_gain * i_x;
        end
    end

    // Stage 2: three partial sums of three; rounding half folded into the first
    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            n_part[g] = PART_W'(r_prod[3*g]) + PART_W'(r_prod[3*g+1])
                      + PART_W'(r_prod[3*g+2]);
        end
        n_part[0] = n_part[0] + HALF;
    end

    // Stage 3: final sum, floor shift, saturation
    always_comb begin
        acc = ACC_W'(r_part[0]) + ACC_W'(r_part[1]) + ACC_W'(r_part[2]);
        rnd = acc >>> COEF_FRAC_BITS;
        if (rnd > SAT_HI) begin
            n_out = SAT_HI[SMP_W-1:0];
        end else if (rnd < SAT_LO) begin
            n_out = SAT_LO[SMP_W-1:0];
        end else begin
            n_out = rnd[SMP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_prod <= n_prod;
        end
        if (i_en.s2) begin
            r_part <= n_part;
        end
        if (i_en.s3) begin
            r_out <= n_out;
        end
    end

    assign o_result = r_out;

endmodule

`default_nettype wire

// ----- sv/stream_mix_matrix_vector.sv -----
// Stream mixing block, top level: eight lanes mix residual streams per beat.
// A data beat's result passes the stage-1 product, stage-2 partial-sum and stage-3 output registers before it is valid.
// Throughput: one beat per cycle while the output is ready; set by the three-stage lane pipeline.
// Load beats update the store at acceptance and give no result.
// Reset (synchronous, active low): store zero, stream count 4, pipeline empty.
// Depends on smmv_pkg, smmv_if, smmv_apb_regs, smmv_coef_store, smmv_lane.
`default_nettype none

module stream_mix_matrix_vector
    import smmv_pkg::*;
#(
    parameter int MAX_STREAMS    = MAX_STREAMS_DEF,
    parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    smmv_in_if.sink                    i_in,
    smmv_out_if.source                 o_out,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    logic [CNT_W-1:0]         count;
    logic                     count_ok;
    logic                     in_acc;
    logic                     ld1;
    logic                     ld2;
    logic                     ld3;
    logic                     take3;
    logic                     r_v1;
    logic                     r_v2;
    logic                     r_v3;
    logic                     n_v1;
    logic                     n_v2;
    logic                     n_v3;
    t_pipe_en                 pipe_en;
    t_coef_wr                 coef_wr;
    logic signed [SMP_W-1:0]  res    [LANES];
    logic signed [SMP_W-1:0]  result [LANES];
    logic signed [COEF_W-1:0] mix    [MATRIX_DEPTH];
    logic signed [COEF_W-1:0] gain   [LANES];

    // Configuration registers
    smmv_apb_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_count   (count)
    );

    assign count_ok = (count != '0) && (count <= CNT_W'(MAX_STREAMS));

    // Pipeline control: each stage loads when the one after it is empty or drains
    assign take3 = r_v3 && o_out.ready;
    assign ld3   = r_v2 && (!r_v3 || take3);
    assign ld2   = r_v1 && (!r_v2 || ld3);
    assign i_in.ready = !r_v1 || ld2;
    assign in_acc = i_in.valid && i_in.ready;
    assign ld1    = in_acc && (i_in.func == FUNC_DATA) && count_ok;

    assign n_v1 = ld1 || (r_v1 && !ld2);
    assign n_v2 = ld2 || (r_v2 && !ld3);
    assign n_v3 = ld3 || (r_v3 && !take3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
        end
    end

    assign pipe_en.s1 = ld1;
    assign pipe_en.s2 = ld2;
    assign pipe_en.s3 = ld3;

    // Coefficient store, written by load beats
    assign coef_wr.we    = in_acc && (i_in.func == FUNC_LOAD);
    assign coef_wr.index = i_in.coef_index;
    assign coef_wr.value = i_in.coef_value;

    smmv_coef_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (coef_wr),
        .o_mix   (mix),
        .o_gain  (gain)
    );

    assign res[0] = i_in.res_lane0;
    assign res[1] = i_in.res_lane1;
    assign res[2] = i_in.res_lane2;
    assign res[3] = i_in.res_lane3;
    assign res[4] = i_in.res_lane4;
    assign res[5] = i_in.res_lane5;
    assign res[6] = i_in.res_lane6;
    assign res[7] = i_in.res_lane7;

    // Lanes: lane o takes matrix column o and post gain o
    for (genvar o = 0; o < LANES; o++) begin : g_lane
        logic signed [COEF_W-1:0] col [LANES];

        for (genvar i = 0; i < LANES; i++) begin : g_col
            assign col[i] = mix[i*LANES + o];
        end

        smmv_lane #(
            .LANE           (o),
            .SAMPLE_WIDTH   (SAMPLE_WIDTH),
            .COEF_FRAC_BITS (COEF_FRAC_BITS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_en     (pipe_en),
            .i_count  (count),
            .i_x      (i_in.x_value),
            .i_res    (res),
            .i_col    (col),
            .i_gain   (gain[o]),
            .o_result (result[o])
        );
    end

    // Merge: lane results form one output beat
    assign o_out.valid     = r_v3;
    assign o_out.out_lane0 = result[0];
    assign o_out.out_lane1 = result[1];
    assign o_out.out_lane2 = result[2];
    assign o_out.out_lane3 = result[3];
    assign o_out.out_lane4 = result[4];
    assign o_out.out_lane5 = result[5];
    assign o_out.out_lane6 = result[6];
    assign o_out.out_lane7 = result[7];

    // Checks on pipeline control and configuration
    a_data_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ld1 |=> r_v1)
        else $error("accepted data beat did not enter stage 1");

    a_other_skipped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !ld1 |=> !r_v1)
        else $error("load or dropped beat entered the pipeline");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> r_v1 && r_v2 && r_v3 && !o_out.ready)
        else $error("input stalled with room in the pipeline");

    a_s2_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && !r_v3 |=> r_v3)
        else $error("stage 2 beat lost");

    a_count_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && (paddr[2] == REG_STREAM_COUNT)
        |=> count == $past(pwdata[CNT_W-1:0]))
        else $error("stream count write not taken");

endmodule

`default_nettype wire
